FILE: rtl/oott_pkg.sv
// Shared constants, status codes and the timer entry type of the timer table.
package oott_pkg;

  localparam int TimerSlots = 16;
  localparam int HandleW    = 8;
  localparam int SlotIdxW   = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int CntW       = $clog2(TimerSlots + 1);

  localparam logic [1:0] StScheduled = 2'd0;
  localparam logic [1:0] StFull      = 2'd1;
  localparam logic [1:0] StFired     = 2'd2;
  localparam logic [1:0] StIdle      = 2'd3;

  localparam logic ModeSchedule = 1'b0;
  localparam logic ModeRun      = 1'b1;

  typedef struct packed {
    logic [31:0]        start_ts;
    logic [31:0]        delay;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

FILE: rtl/oott_cell.sv
// One timer slot: loads a new entry, takes its upper neighbor's entry, or holds.
module oott_cell import oott_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_i,
  input  logic   wr_i,
  input  entry_t nbr_i,
  input  entry_t wr_data_i,
  output entry_t entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (wr_i) begin
      entry_d = wr_data_i;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/oneshot_timer_table_unit.sv
// One-shot timer table: schedule appends at the tail, run fires and removes due timers.
// Schedule: busy stays low; the single result strobes in the cycle after start.
// Run over n live timers: busy until all n are walked; the head cell is checked once per cycle,
// a fired result strobes the cycle after the next due check or the end of the walk.
// Throughput: one schedule per cycle; no new item is taken until a run ends; the receiver cannot stall.
// Reset empties the table (count cleared); slot contents are not cleared.
module oneshot_timer_table_unit import oott_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [31:0]        now_i,
  input  logic [31:0]        delay_i,
  input  logic [HandleW-1:0] handle_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [HandleW-1:0] fired_handle_o,
  output logic               last_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SRun  = 1'b1;

  logic               state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    kept_q, kept_d;
  logic [31:0]        now_q, now_d;
  logic               pend_q, pend_d;
  logic [HandleW-1:0] pend_handle_q, pend_handle_d;
  logic               done_q, done_d;
  logic [1:0]         status_q, status_d;
  logic [HandleW-1:0] fhandle_q, fhandle_d;
  logic               last_q, last_d;

  entry_t             cell_entry [TimerSlots];
  entry_t             head;
  entry_t             wr_data;
  logic               shift;
  logic               wr_en;
  logic [SlotIdxW-1:0] wr_idx;
  logic [CntW-1:0]    wr_pos;
  logic [31:0]        elapsed;
  logic               due;
  logic               accept;

  assign head    = cell_entry[0];
  assign elapsed = now_q - head.start_ts;
  assign due     = (elapsed >= head.delay);
  assign accept  = start && !busy;
  assign wr_pos  = rem_q - CntW'(1) + kept_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    kept_d        = kept_q;
    now_d         = now_q;
    pend_d        = pend_q;
    pend_handle_d = pend_handle_q;
    done_d        = 1'b0;
    status_d      = status_q;
    fhandle_d     = fhandle_q;
    last_d        = last_q;
    shift         = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = cnt_q[SlotIdxW-1:0];
    wr_data       = '{start_ts: now_i, delay: delay_i, handle: handle_i};

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (mode_i == ModeSchedule) begin
            done_d    = 1'b1;
            fhandle_d = '0;
            last_d    = 1'b1;
            if (cnt_q == CntW'(TimerSlots)) begin
              status_d = StFull;
            end else begin
              status_d = StScheduled;
              wr_en    = 1'b1;
              cnt_d    = cnt_q + CntW'(1);
            end
          end else begin
            state_d = SRun;
            now_d   = now_i;
            rem_d   = cnt_q;
            kept_d  = '0;
            pend_d  = 1'b0;
          end
        end
      end
      SRun: begin
        if (rem_q != '0) begin
          // pop the head; a survivor goes back right after the earlier survivors
          shift   = 1'b1;
          wr_data = head;
          wr_idx  = wr_pos[SlotIdxW-1:0];
          rem_d   = rem_q - CntW'(1);
          if (due) begin
            if (pend_q) begin
              done_d    = 1'b1;
              status_d  = StFired;
              fhandle_d = pend_handle_q;
              last_d    = 1'b0;
            end
            pend_d        = 1'b1;
            pend_handle_d = head.handle;
          end else begin
            wr_en  = 1'b1;
            kept_d = kept_q + CntW'(1);
          end
        end else begin
          done_d  = 1'b1;
          last_d  = 1'b1;
          cnt_d   = kept_q;
          state_d = SIdle;
          if (pend_q) begin
            status_d  = StFired;
            fhandle_d = pend_handle_q;
          end else begin
            status_d  = StIdle;
            fhandle_d = '0;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  for (genvar i = 0; i < TimerSlots; i++) begin : g_cell
    entry_t nbr;
    if (i == TimerSlots - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_entry[i+1];
    end

    oott_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .wr_i      (wr_en && (wr_idx == SlotIdxW'(i))),
      .nbr_i     (nbr),
      .wr_data_i (wr_data),
      .entry_o   (cell_entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      rem_q   <= '0;
      kept_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      kept_q  <= kept_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q         <= now_d;
    pend_handle_q <= pend_handle_d;
    status_q      <= status_d;
    fhandle_q     <= fhandle_d;
    last_q        <= last_d;
  end

  assign busy           = (state_q == SRun);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign fired_handle_o = fhandle_q;
  assign last_o         = last_q;

endmodule

FILE: tb/sv/oneshot_timer_table_unit_tb.sv
// Self-checking testbench of the one-shot timer table: directed cases, then random items.
module oneshot_timer_table_unit_tb;
  import oott_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [1:0]         status;
    logic [HandleW-1:0] handle;
    logic               last;
  } timer_event_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               mode_i;
  logic [31:0]        now_i;
  logic [31:0]        delay_i;
  logic [HandleW-1:0] handle_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [HandleW-1:0] fired_handle_o;
  logic               last_o;

  // Predicted table contents, oldest timer first
  logic [31:0]        tbl_start  [TimerSlots];
  logic [31:0]        tbl_delay  [TimerSlots];
  logic [HandleW-1:0] tbl_handle [TimerSlots];
  int                 tbl_fill;

  timer_event_t timer_events_q[$];
  timer_event_t seen_ev;
  int           err_cnt;
  int           cycle_cnt;
  bit           idle_on;

  oneshot_timer_table_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .now_i         (now_i),
    .delay_i       (delay_i),
    .handle_i      (handle_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .fired_handle_o(fired_handle_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the events that one accepted item causes and update the table copy.
  function automatic void apply_timer_item(logic m, logic [31:0] now, logic [31:0] dly,
                                           logic [HandleW-1:0] hnd);
    int           keep;
    int           fired;
    logic [31:0]  elapsed;
    timer_event_t ev;
    if (m == ModeSchedule) begin
      ev.handle = '0;
      ev.last   = 1'b1;
      if (tbl_fill >= TimerSlots) begin
        ev.status = StFull;
      end else begin
        tbl_start[tbl_fill]  = now;
        tbl_delay[tbl_fill]  = dly;
        tbl_handle[tbl_fill] = hnd;
        tbl_fill++;
        ev.status = StScheduled;
      end
      timer_events_q.push_back(ev);
    end else begin
      keep  = 0;
      fired = 0;
      for (int i = 0; i < tbl_fill; i++) begin
        elapsed = now - tbl_start[i];
        if (elapsed >= tbl_delay[i]) begin
          ev.status = StFired;
          ev.handle = tbl_handle[i];
          ev.last   = 1'b0;
          timer_events_q.push_back(ev);
          fired++;
        end else begin
          // close up the survivors in order
          tbl_start[keep]  = tbl_start[i];
          tbl_delay[keep]  = tbl_delay[i];
          tbl_handle[keep] = tbl_handle[i];
          keep++;
        end
      end
      tbl_fill = keep;
      if (fired == 0) begin
        ev.status = StIdle;
        ev.handle = '0;
        ev.last   = 1'b1;
        timer_events_q.push_back(ev);
      end else begin
        timer_events_q[timer_events_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // Predict on acceptance first, so a result in the same cycle still finds its event.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_timer_item(mode_i, now_i, delay_i, handle_i);
      end
      if (done_o) begin
        if (timer_events_q.size() == 0) begin
          $error("unexpected result: status %0d fired_handle %0d last %0d",
                 status_o, fired_handle_o, last_o);
          err_cnt++;
        end else begin
          seen_ev = timer_events_q.pop_front();
          if (status_o !== seen_ev.status) begin
            $error("status: expected %0d, actual %0d", seen_ev.status, status_o);
            err_cnt++;
          end
          if (fired_handle_o !== seen_ev.handle) begin
            $error("fired_handle: expected %0d, actual %0d", seen_ev.handle, fired_handle_o);
            err_cnt++;
          end
          if (last_o !== seen_ev.last) begin
            $error("last: expected %0d, actual %0d", seen_ev.last, last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_timer_item(input logic m, input logic [31:0] now, input logic [31:0] dly,
                                 input logic [HandleW-1:0] hnd);
    start    <= 1'b1;
    mode_i   <= m;
    now_i    <= now;
    delay_i  <= dly;
    handle_i <= hnd;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a random burst, with junk on the fields.
  task automatic maybe_idle();
    int gap;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 16);
      start    <= 1'b0;
      mode_i   <= 1'($urandom_range(0, 1));
      now_i    <= $urandom;
      delay_i  <= $urandom;
      handle_i <= HandleW'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: pick_delay = 32'd0;
      1: pick_delay = 32'hFFFF_FFFF;
      2: pick_delay = $urandom;
      default: pick_delay = $urandom_range(1, 64);
    endcase
  endfunction

  task automatic test_extremes();
    send_timer_item(ModeRun, 32'd0, 32'hFFFF_FFFF, 8'hFF);    // empty table: nothing due
    maybe_idle();
    send_timer_item(ModeSchedule, 32'd0, 32'd0, 8'h00);
    maybe_idle();
    send_timer_item(ModeSchedule, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    maybe_idle();
    // elapsed 1 across the wrap keeps the second timer
    send_timer_item(ModeRun, 32'd0, 32'd0, 8'h00);
    maybe_idle();
    // run time just before the start counts as almost a full wrap
    send_timer_item(ModeRun, 32'hFFFF_FFFE, 32'd0, 8'h00);
    maybe_idle();
  endtask

  task automatic test_full_table();
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < TimerSlots; i++) begin
      send_timer_item(ModeSchedule, base, (i % 2 == 1) ? 32'h1000 : 32'd0,
                      HandleW'($urandom_range(0, 255)));
      maybe_idle();
    end
    send_timer_item(ModeSchedule, $urandom, $urandom, HandleW'($urandom_range(0, 255)));
    maybe_idle();
    // fire the even slots, then the odd ones after closing up
    send_timer_item(ModeRun, base, $urandom, HandleW'($urandom_range(0, 255)));
    maybe_idle();
    send_timer_item(ModeRun, base + 32'h1000, $urandom, HandleW'($urandom_range(0, 255)));
    maybe_idle();
  endtask

  task automatic run_random_items(input int count);
    logic [31:0] cur_time;
    int          r;
    cur_time = $urandom;
    if ($urandom_range(0, 3) == 0) cur_time = 32'hFFFF_FF00 + $urandom_range(0, 255);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_timer_item(ModeSchedule, cur_time, pick_delay(),
                        HandleW'($urandom_range(0, 255)));
      end else if (r < 85) begin
        send_timer_item(ModeRun, cur_time, $urandom, HandleW'($urandom_range(0, 255)));
      end else if (r < 93) begin
        send_timer_item(ModeSchedule, $urandom, $urandom, HandleW'($urandom_range(0, 255)));
      end else begin
        send_timer_item(ModeRun, $urandom, $urandom, HandleW'($urandom_range(0, 255)));
      end
      cur_time = cur_time + $urandom_range(0, 24);
      maybe_idle();
    end
  endtask

  task automatic test_random_with_idling();
    idle_on = 1'b1;
    run_random_items(125);
  endtask

  task automatic test_random_back_to_back();
    idle_on = 1'b0;
    run_random_items(30);
  endtask

  initial begin
    err_cnt   = 0;
    cycle_cnt = 0;
    tbl_fill  = 0;
    idle_on   = 1'b1;
    rst_ni   <= 1'b0;
    start    <= 1'b0;
    mode_i   <= ModeSchedule;
    now_i    <= '0;
    delay_i  <= '0;
    handle_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_full_table();
    test_random_with_idling();
    test_random_back_to_back();

    start <= 1'b0;
    while (timer_events_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/oott_pkg.sv
rtl/oott_cell.sv
rtl/oneshot_timer_table_unit.sv
tb/sv/oneshot_timer_table_unit_tb.sv
